// File: rtl/assert_macros.svh
// Assertion macros shared by the envelope generator RTL.
// Depends on nothing; the asserting module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while rst_n is low.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition is never true, off while rst_n is low.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/adsr_pkg.sv
// Shared constants for the linear envelope generator.
// Depends on nothing; used by the interfaces and all modules.
package adsr_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LVL_W         = 16;
    localparam int DEF_SEG_BITS  = 20;
    localparam int DEF_FRAC_BITS = 15;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_LEVEL1  = 3'd4;
    localparam logic [2:0] REG_LEVEL2  = 3'd5;
    localparam logic [2:0] REG_MUTE    = 3'd6;

    localparam int RST_ATTACK  = 441;
    localparam int RST_DECAY   = 2205;
    localparam int RST_SUSTAIN = 4410;
    localparam int RST_RELEASE = 4410;
    localparam int RST_LEVEL1  = 22938;
    localparam int RST_LEVEL2  = 3277;

endpackage

// File: rtl/adsr_if.sv
// Valid/ready stream interfaces for sample requests and envelope results.
// Depends on adsr_pkg.
interface adsr_in_if;
    import adsr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       retrigger;

    modport source (output valid, output sample_in, output retrigger, input ready);
    modport sink (input valid, input sample_in, input retrigger, output ready);
endinterface

interface adsr_out_if;
    import adsr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] env_out;
    logic                       env_active;

    modport source (output valid, output env_out, output env_active, input ready);
    modport sink (input valid, input env_out, input env_active, output ready);
endinterface

// File: rtl/adsr_envelope_generator_unit.sv
// Top level of the linear attack/decay/sustain/release envelope generator.
// Depends on adsr_pkg, adsr_if.sv, adsr_divider and assert_macros.svh.
//   sample_req carries one request per audio sample: sample_in (signed Q1.15,
//   nonzero is a click that sets the gain and restarts) and retrigger.
//   env_req returns one result per request: env_out (signed Q1.15, saturated)
//   and env_active. Both channels move a request when valid and ready are high.
//   The APB port writes the seven envelope registers at byte address 4*index;
//   pready is tied high and reads return the register values.
// Sequence:
//   A request is taken only while the sequencer is idle. It then locates its
//   segment (one add and compare per segment), forms the interpolation
//   numerator from two products on the shared multiplier, runs the restoring
//   divider (LVW quotient bits, LVW = max(16, FRAC_BITS+1), 16 at defaults),
//   does one multiply to apply the gain and then saturates. The sequencer
//   returns to idle as the result is registered. Past the end of release the
//   divider is skipped and the envelope is zero.
//   Muted: result zero, state frozen.
// Reset clears position, gain, sequencer and output valid, and loads the
// register defaults. A stalled receiver holds the result in the output
// register; a finished result waits in the final state until the slot frees.
module adsr_envelope_generator_unit #(
    parameter int SEG_BITS  = adsr_pkg::DEF_SEG_BITS,
    parameter int FRAC_BITS = adsr_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    adsr_in_if.sink                       sample_req,
    adsr_out_if.source                    env_req,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [adsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [adsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import adsr_pkg::*;
    `include "assert_macros.svh"

    // level width: holds the 16-bit levels and 1.0
    localparam int LVW  = (FRAC_BITS + 1 > LVL_W) ? FRAC_BITS + 1 : LVL_W;
    localparam int MB   = (SEG_BITS + 1 > SAMPLE_W) ? SEG_BITS + 1 : SAMPLE_W;
    localparam int PW   = LVW + 1 + MB;
    localparam int NUMW = LVW + SEG_BITS;
    localparam int POSW = SEG_BITS + 2;
    localparam logic [LVW-1:0] UNITY = LVW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
    localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEG   = 3'd1;
    localparam logic [2:0] ST_MULA  = 3'd2;
    localparam logic [2:0] ST_MULB  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [1:0] SEG_ATT = 2'd0;
    localparam logic [1:0] SEG_DEC = 2'd1;
    localparam logic [1:0] SEG_SUS = 2'd2;
    localparam logic [1:0] SEG_REL = 2'd3;

    // ---------------- configuration registers ----------------
    logic [SEG_BITS-1:0] attack_len_reg, decay_len_reg, sustain_len_reg, release_len_reg;
    logic [LVL_W-1:0]    level_one_reg, level_two_reg;
    logic                mute_on_reg;
    logic [2:0]          reg_idx;
    logic                cfg_write;

    assign reg_idx   = paddr[4:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg  <= SEG_BITS'(RST_ATTACK);
            decay_len_reg   <= SEG_BITS'(RST_DECAY);
            sustain_len_reg <= SEG_BITS'(RST_SUSTAIN);
            release_len_reg <= SEG_BITS'(RST_RELEASE);
            level_one_reg   <= LVL_W'(RST_LEVEL1);
            level_two_reg   <= LVL_W'(RST_LEVEL2);
            mute_on_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_ATTACK:  attack_len_reg  <= pwdata[SEG_BITS-1:0];
                REG_DECAY:   decay_len_reg   <= pwdata[SEG_BITS-1:0];
                REG_SUSTAIN: sustain_len_reg <= pwdata[SEG_BITS-1:0];
                REG_RELEASE: release_len_reg <= pwdata[SEG_BITS-1:0];
                REG_LEVEL1:  level_one_reg   <= pwdata[LVL_W-1:0];
                REG_LEVEL2:  level_two_reg   <= pwdata[LVL_W-1:0];
                REG_MUTE:    mute_on_reg     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ATTACK:  prdata = APB_DATA_W'(attack_len_reg);
            REG_DECAY:   prdata = APB_DATA_W'(decay_len_reg);
            REG_SUSTAIN: prdata = APB_DATA_W'(sustain_len_reg);
            REG_RELEASE: prdata = APB_DATA_W'(release_len_reg);
            REG_LEVEL1:  prdata = APB_DATA_W'(level_one_reg);
            REG_LEVEL2:  prdata = APB_DATA_W'(level_two_reg);
            REG_MUTE:    prdata = APB_DATA_W'(mute_on_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    logic [2:0]                 state_reg, state_next;
    logic [POSW-1:0]            position_reg, position_next;
    logic signed [SAMPLE_W-1:0] held_gain_reg, held_gain_next;
    logic                       muted_reg, muted_next;
    logic                       active_reg, active_next;
    logic [1:0]                 seg_idx_reg, seg_idx_next;
    logic [POSW-1:0]            base_reg, base_next;
    logic [SEG_BITS-1:0]        k_reg, k_next;
    logic [SEG_BITS-1:0]        len_reg, len_next;
    logic [LVW-1:0]             from_reg, from_next;
    logic [LVW-1:0]             to_reg, to_next;
    logic [NUMW-1:0]            num_reg, num_next;
    logic [LVW-1:0]             env_reg, env_next;
    logic signed [PW-1:0]       prod_reg, prod_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_env_reg, out_env_next;
    logic                       out_active_reg, out_active_next;

    // shared multiplier
    logic signed [LVW:0]   mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;

    // segment search
    logic [SEG_BITS-1:0] len_sel;
    logic [LVW-1:0]      from_sel, to_sel;
    logic [POSW-1:0]     lim;

    // result shaping
    logic signed [PW-1:0] scaled, env_wide, val;
    logic                 out_free;

    // divider
    logic           div_start;
    logic           div_done;
    logic [LVW-1:0] div_quo;

    always_comb
    begin
        case (seg_idx_reg)
            SEG_ATT:
            begin
                len_sel  = attack_len_reg;
                from_sel = '0;
                to_sel   = UNITY;
            end
            SEG_DEC:
            begin
                len_sel  = decay_len_reg;
                from_sel = UNITY;
                to_sel   = LVW'(level_one_reg);
            end
            SEG_SUS:
            begin
                len_sel  = sustain_len_reg;
                from_sel = LVW'(level_one_reg);
                to_sel   = LVW'(level_two_reg);
            end
            default:
            begin
                len_sel  = release_len_reg;
                from_sel = LVW'(level_two_reg);
                to_sel   = '0;
            end
        endcase
    end

    assign lim = base_reg + POSW'(len_sel);

    always_comb
    begin
        case (state_reg)
            ST_MULA:
            begin
                mul_a = (LVW+1)'(from_reg);
                mul_b = MB'(len_reg - k_reg);
            end
            ST_MULB:
            begin
                mul_a = (LVW+1)'(to_reg);
                mul_b = MB'(k_reg);
            end
            default:
            begin
                mul_a = (LVW+1)'(env_reg);
                mul_b = MB'(held_gain_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor division by 1.0 is an arithmetic shift
    assign scaled   = prod_reg >>> FRAC_BITS;
    assign env_wide = PW'(env_reg);
    assign val      = (held_gain_reg == '0) ? env_wide : scaled;
    assign out_free = !out_valid_reg || env_req.ready;

    assign div_start = (state_reg == ST_MULB);

    always_comb
    begin
        state_next      = state_reg;
        position_next   = position_reg;
        held_gain_next  = held_gain_reg;
        muted_next      = muted_reg;
        active_next     = active_reg;
        seg_idx_next    = seg_idx_reg;
        base_next       = base_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        num_next        = num_reg;
        env_next        = env_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !env_req.ready;
        out_env_next    = out_env_reg;
        out_active_next = out_active_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_req.valid)
                begin
                    muted_next   = mute_on_reg;
                    seg_idx_next = SEG_ATT;
                    base_next    = '0;
                    if (mute_on_reg)
                    begin
                        // drop the request, freeze the envelope
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (sample_req.sample_in != '0)
                        begin
                            held_gain_next = sample_req.sample_in;
                            position_next  = '0;
                        end
                        if (sample_req.retrigger)
                            position_next = '0;
                        state_next = ST_SEG;
                    end
                end
            end
            ST_SEG:
            begin
                if (position_reg < lim)
                begin
                    k_next        = SEG_BITS'(position_reg - base_reg);
                    len_next      = len_sel;
                    from_next     = from_sel;
                    to_next       = to_sel;
                    active_next   = 1'b1;
                    position_next = position_reg + 1'b1;
                    state_next    = ST_MULA;
                end
                else if (seg_idx_reg == SEG_REL)
                begin
                    // past end of release: hold position, envelope is zero
                    active_next = 1'b0;
                    env_next    = '0;
                    state_next  = ST_SCALE;
                end
                else
                begin
                    base_next    = lim;
                    seg_idx_next = seg_idx_reg + 1'b1;
                end
            end
            ST_MULA:
            begin
                num_next   = mul_p[NUMW-1:0];
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                num_next   = num_reg + mul_p[NUMW-1:0];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    env_next   = div_quo;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                prod_next  = mul_p;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (muted_reg)
                    begin
                        out_env_next    = '0;
                        out_active_next = 1'b0;
                    end
                    else
                    begin
                        if (val > SAT_HI)
                            out_env_next = SAMPLE_W'(SAT_HI);
                        else if (val < SAT_LO)
                            out_env_next = SAMPLE_W'(SAT_LO);
                        else
                            out_env_next = val[SAMPLE_W-1:0];
                        out_active_next = active_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            held_gain_reg <= '0;
            muted_reg     <= 1'b0;
            active_reg    <= 1'b0;
            seg_idx_reg   <= SEG_ATT;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            held_gain_reg <= held_gain_next;
            muted_reg     <= muted_next;
            active_reg    <= active_next;
            seg_idx_reg   <= seg_idx_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        len_reg        <= len_next;
        from_reg       <= from_next;
        to_reg         <= to_next;
        num_reg        <= num_next;
        env_reg        <= env_next;
        prod_reg       <= prod_next;
        out_env_reg    <= out_env_next;
        out_active_reg <= out_active_next;
    end

    // interpolation quotient, one bit per cycle
    adsr_divider #(
        .SEG_BITS (SEG_BITS),
        .QUO_W    (LVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_next),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sample_req.ready   = (state_reg == ST_IDLE);
    assign env_req.valid      = out_valid_reg;
    assign env_req.env_out    = out_env_reg;
    assign env_req.env_active = out_active_reg;

    `ASSERT_CLKD(a_accept_leaves_idle,
        (sample_req.valid && sample_req.ready) |=> (state_reg != ST_IDLE),
        "request accepted but sequencer stayed idle")
    `ASSERT_CLKD(a_result_from_done,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE),
        "result registered outside the final state")
    `ASSERT_NEVER(a_div_done_stray,
        div_done && (state_reg != ST_DIV),
        "divider finished while sequencer not waiting on it")

endmodule

// File: rtl/adsr_divider.sv
// Restoring divider, one quotient bit per cycle, for segment interpolation.
// Depends on adsr_pkg (imported for project consistency).
module adsr_divider #(
    parameter int SEG_BITS = adsr_pkg::DEF_SEG_BITS,
    parameter int QUO_W    = adsr_pkg::LVL_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SEG_BITS+QUO_W-1:0] num,
    input  logic [SEG_BITS-1:0]       divisor,
    output logic                      done,
    output logic [QUO_W-1:0]          quotient
);
    import adsr_pkg::*;

    localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SEG_BITS-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;

    logic [SEG_BITS:0] trial;
    logic [SEG_BITS:0] diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // upper part is already below the divisor since the quotient fits QUO_W
            rem_next  = num[SEG_BITS+QUO_W-1:QUO_W];
            quo_next  = num[QUO_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[SEG_BITS-1:0] : trial[SEG_BITS-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sim/adsr_envelope_checker.sv
`timescale 1ns / 1ps
// Envelope checker: snoops the APB writes and both request channels.
// Depends on adsr_pkg; predicts every result and compares it on arrival.
module adsr_envelope_checker
    import adsr_pkg::*;
#(
    parameter int SEG_BITS  = DEF_SEG_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic signed [SAMPLE_W-1:0]   req_sample,
    input  logic                         req_retrigger,
    input  logic                         res_valid,
    input  logic                         res_ready,
    input  logic signed [SAMPLE_W-1:0]   res_level,
    input  logic                         res_active,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output int                           fail_count,
    output int                           pending,
    output int                           checked_count,
    output int                           active_count,
    output int                           saturated_count,
    output int                           muted_count
);

    localparam longint unsigned UNITY    = 64'd1 << FRAC_BITS;
    localparam longint unsigned SEG_MASK = (64'd1 << SEG_BITS) - 64'd1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] level;
        logic                       active;
    } env_result_t;

    env_result_t env_expect_q[$];

    longint unsigned atk_len, dec_len, sus_len, rel_len;
    longint unsigned level_one, level_two;
    logic            muted;
    logic [SEG_BITS+1:0]        pos_q;
    logic signed [SAMPLE_W-1:0] gain_q;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint unsigned ramp_value(input longint unsigned from_lvl,
                                                   input longint unsigned to_lvl,
                                                   input longint unsigned k,
                                                   input longint unsigned len);
        return (from_lvl * (len - k) + to_lvl * k) / len;
    endfunction

    // Locate the segment; empty segments never match, so no divide by zero.
    function automatic longint unsigned env_level(input longint unsigned pos);
        longint unsigned b1, b2, b3, stop;
        b1   = atk_len;
        b2   = b1 + dec_len;
        b3   = b2 + sus_len;
        stop = b3 + rel_len;
        if (pos < b1)
            return ramp_value(0, UNITY, pos, atk_len);
        if (pos < b2)
            return ramp_value(UNITY, level_one, pos - b1, dec_len);
        if (pos < b3)
            return ramp_value(level_one, level_two, pos - b2, sus_len);
        if (pos < stop)
            return ramp_value(level_two, 0, pos - b3, rel_len);
        return 0;
    endfunction

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        case (addr[APB_ADDR_W-1:2])
            REG_ATTACK:  atk_len   = data & SEG_MASK;
            REG_DECAY:   dec_len   = data & SEG_MASK;
            REG_SUSTAIN: sus_len   = data & SEG_MASK;
            REG_RELEASE: rel_len   = data & SEG_MASK;
            REG_LEVEL1:  level_one = data[LVL_W-1:0];
            REG_LEVEL2:  level_two = data[LVL_W-1:0];
            REG_MUTE:    muted     = data[0];
            default: ;
        endcase
    endtask

    task automatic predict_request(input logic signed [SAMPLE_W-1:0] smp,
                                   input logic retrig);
        longint unsigned lvl, stop;
        longint          scaled;
        env_result_t     r;
        if (muted) begin
            // muted: drop the request, freeze state
            r.level = '0;
            r.active = 1'b0;
            muted_count++;
        end else begin
            if (smp != 0) begin
                gain_q = smp;
                pos_q  = '0;
            end
            if (retrig)
                pos_q = '0;
            stop = atk_len + dec_len + sus_len + rel_len;
            lvl  = env_level(longint'(pos_q));
            r.active = (longint'(pos_q) < stop);
            if (gain_q != 0)
                scaled = (longint'(lvl) * longint'(gain_q)) >>> FRAC_BITS;
            else
                scaled = longint'(lvl);
            if (scaled > 32767) begin
                scaled = 32767;
                saturated_count++;
            end else if (scaled < -32768) begin
                scaled = -32768;
                saturated_count++;
            end
            r.level = scaled[SAMPLE_W-1:0];
            if (r.active) begin
                pos_q = pos_q + 1'b1;
                active_count++;
            end
        end
        env_expect_q.push_back(r);
    endtask

    task automatic check_result(input logic signed [SAMPLE_W-1:0] got_level,
                                input logic got_active);
        env_result_t want;
        if (env_expect_q.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding: env_out=%0d env_active=%b",
                                      got_level, got_active));
        end else begin
            want = env_expect_q.pop_front();
            checked_count++;
            if (got_level !== want.level)
                report_mismatch($sformatf("env_out: got %0d, want %0d", got_level, want.level));
            if (got_active !== want.active)
                report_mismatch($sformatf("env_active: got %b, want %b",
                                          got_active, want.active));
        end
    endtask

    // Results first: a result leaving at an edge never belongs to a request
    // taken at that same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_len   = RST_ATTACK;
            dec_len   = RST_DECAY;
            sus_len   = RST_SUSTAIN;
            rel_len   = RST_RELEASE;
            level_one = RST_LEVEL1;
            level_two = RST_LEVEL2;
            muted     = 1'b0;
            pos_q     = '0;
            gain_q    = '0;
            env_expect_q.delete();
            pending   = 0;
        end
        else
        begin
            if (res_valid && res_ready)
                check_result(res_level, res_active);
            if (psel && penable && pwrite && pready)
                write_register(paddr, pwdata);
            if (req_valid && req_ready)
                predict_request(req_sample, req_retrigger);
            pending = env_expect_q.size();
        end
    end

endmodule

// File: sim/adsr_envelope_generator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the linear envelope generator: clock, reset, stimulus.
// Depends on adsr_pkg, adsr_if.sv, the generator RTL and adsr_envelope_checker.
module adsr_envelope_generator_unit_tb;
    import adsr_pkg::*;

    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 8;        // result to idle margin, generous
    localparam int LIMIT_CYCLES  = 600000;
    localparam int MAX_SEG       = (1 << DEF_SEG_BITS) - 1;
    localparam int UNITY_LVL     = 1 << DEF_FRAC_BITS;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count, pending, checked_count, active_count, saturated_count, muted_count;
    int cycle_count;
    int burst_left;
    int restart_pct;
    int directed_count;
    int random_count;
    int setting_count;

    adsr_in_if  sample_req();
    adsr_out_if env_req();

    adsr_envelope_generator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_req (sample_req),
        .env_req    (env_req),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Watch both channels and the register port; predict and compare there.
    adsr_envelope_checker env_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (sample_req.valid),
        .req_ready       (sample_req.ready),
        .req_sample      (sample_req.sample_in),
        .req_retrigger   (sample_req.retrigger),
        .res_valid       (env_req.valid),
        .res_ready       (env_req.ready),
        .res_level       (env_req.env_out),
        .res_active      (env_req.env_active),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked_count   (checked_count),
        .active_count    (active_count),
        .saturated_count (saturated_count),
        .muted_count     (muted_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: rotate through stall patterns so back pressure lands on
    // every phase of the sequencer - none, coin flip, fixed duty, long holds.
    initial
    begin
        int rx_tick;
        rx_tick = 0;
        env_req.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            case ((rx_tick / 700) % 4)
                0:       env_req.ready <= 1'b1;
                1:       env_req.ready <= ($urandom_range(0, 1) == 1);
                2:       env_req.ready <= ((rx_tick % 7) < 3);
                default: env_req.ready <= ((rx_tick % 48) >= 30);
            endcase
        end
    end

    // Drop valid, wait until every predicted result has come back, then let
    // the sequencer settle. Every register write goes through here first.
    task automatic wait_idle();
        sample_req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle; the write lands on the edge that sees pready.
    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_lengths(input int a, input int d, input int s, input int r);
        apb_write(REG_ATTACK, a);
        apb_write(REG_DECAY, d);
        apb_write(REG_SUSTAIN, s);
        apb_write(REG_RELEASE, r);
        setting_count++;
    endtask

    task automatic set_levels(input int l1, input int l2);
        apb_write(REG_LEVEL1, l1);
        apb_write(REG_LEVEL2, l2);
    endtask

    // Present one request and hold it until taken. Within a burst valid stays
    // high; at the end of a burst drop it for a random gap and scramble the
    // idle payload.
    task automatic send_request(input logic signed [SAMPLE_W-1:0] smp, input logic retrig);
        int roll;
        int gap;
        sample_req.valid     <= 1'b1;
        sample_req.sample_in <= smp;
        sample_req.retrigger <= retrig;
        do
            @(posedge clk);
        while (!sample_req.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                gap = $urandom_range(1, 2);
            else if (roll < 95)
                gap = $urandom_range(3, 12);
            else
                gap = $urandom_range(13, 40);
            sample_req.valid     <= 1'b0;
            sample_req.sample_in <= SAMPLE_W'($urandom);
            sample_req.retrigger <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Mostly short segments so runs cross every breakpoint and the end;
    // now and then empty, long or full-scale ones.
    function automatic int rand_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 8);
        if (roll < 92)
            return $urandom_range(9, 60);
        if (roll < 97)
            return $urandom_range(61, 5000);
        return MAX_SEG;
    endfunction

    // Levels up to 1.0, with extremes and some above 1.0 to force saturation.
    function automatic int rand_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return UNITY_LVL;
        if (roll < 27)
            return $urandom_range(UNITY_LVL + 1, 65535);
        return $urandom_range(0, UNITY_LVL);
    endfunction

    // Mostly plain samples that let the envelope run; clicks and retriggers
    // at a per-setting rate, full-scale clicks now and then.
    task automatic random_request();
        logic signed [SAMPLE_W-1:0] smp;
        logic                       retrig;
        int                         roll;
        smp    = '0;
        retrig = 1'b0;
        roll   = $urandom_range(0, 99);
        if (roll < restart_pct)
        begin
            case ($urandom_range(0, 3))
                0:       retrig = 1'b1;
                1:
                begin
                    retrig = 1'b1;
                    smp = SAMPLE_W'($urandom_range(1, 65535));
                end
                default: smp = SAMPLE_W'($urandom_range(1, 65535));
            endcase
            if ($urandom_range(0, 9) == 0)
                smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        send_request(smp, retrig);
    endtask

    initial
    begin
        int n;
        int phase;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        sample_req.valid     = 1'b0;
        sample_req.sample_in = '0;
        sample_req.retrigger = 1'b0;
        cycle_count          = 0;
        burst_left           = 0;
        restart_pct          = 10;
        directed_count       = 0;
        random_count         = 0;
        setting_count        = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values, gain still unity.
        send_request(16'sd0, 1'b1);
        send_request(16'sd0, 1'b0);

        // Tiny envelope with decay level above 1.0 and unity gain: walk every
        // position through the end; 1.0 and above must clip to full scale.
        set_lengths(1, 2, 1, 2);
        set_levels(40000, UNITY_LVL);
        send_request(16'sd0, 1'b1);
        repeat (6) send_request(16'sd0, 1'b0);

        // Full-scale clicks, click with retrigger, bare retrigger, smallest gain.
        send_request(16'sh7FFF, 1'b0);
        send_request(16'sh8000, 1'b0);
        send_request(16'sd1, 1'b1);
        send_request(16'sd0, 1'b1);
        send_request(-16'sd1, 1'b0);

        // All segments empty: nothing to play.
        set_lengths(0, 0, 0, 0);
        send_request(16'sh5555, 1'b0);

        // Empty attack and sustain; negative full-scale gain on levels above 1.0.
        set_lengths(0, 2, 0, 2);
        set_levels(65535, 0);
        send_request(16'sh8000, 1'b0);
        repeat (3) send_request(16'sd0, 1'b0);

        // Muted: the click and retrigger are dropped, the envelope resumes after.
        apb_write(REG_MUTE, 1);
        send_request(16'sd12345, 1'b1);
        send_request(16'sd0, 1'b0);
        apb_write(REG_MUTE, 0);
        send_request(16'sd0, 1'b0);

        // Shrink the segments under a running envelope: position lands past end.
        set_lengths(8, 8, 8, 8);
        send_request(16'sd100, 1'b0);
        repeat (2) send_request(16'sd0, 1'b0);
        set_lengths(1, 0, 0, 1);
        send_request(16'sd0, 1'b0);
        // unmuted directed requests; the muted ones land in muted_count
        directed_count = 24;

        // Random settings (once full-length segments), each followed by a run of well-formed traffic.
        phase = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (phase == 1)
            begin
                set_lengths(MAX_SEG, MAX_SEG, MAX_SEG, MAX_SEG);
                set_levels(UNITY_LVL, 65535);
            end
            else
            begin
                set_lengths(rand_len(), rand_len(), rand_len(), rand_len());
                set_levels(rand_level(), rand_level());
            end
            restart_pct = $urandom_range(2, 25);
            if ($urandom_range(0, 5) == 0)
            begin
                apb_write(REG_MUTE, 1);
                repeat (6) random_request();
                apb_write(REG_MUTE, 0);
            end
            n = $urandom_range(40, 100);
            repeat (n)
            begin
                random_request();
                random_count++;
                // hold off now and then until the pipeline is empty
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
            phase++;
        end

        wait_idle();
        $display("Sent %0d requests (%0d directed, %0d random, %0d muted)",
                 directed_count + random_count + muted_count, directed_count, random_count,
                 muted_count);
        $display("over %0d segment settings; checked %0d results: %0d active, %0d clipped.",
                 setting_count, checked_count, active_count, saturated_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
